// File: hdl/mces_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element sequencer package
// Payload types, element codes, register indexes and the character table.
// ----------------------------------------------------------------------------
package mces_pkg;

  // Element codes carried on the result channel
  typedef enum logic [1:0] {
    ELEM_DIT   = 2'd0,
    ELEM_DAH   = 2'd1,
    ELEM_SPACE = 2'd2
  } elem_e;

  // Configuration register indexes
  localparam logic [1:0] REG_DIT   = 2'd0;
  localparam logic [1:0] REG_DAH   = 2'd1;
  localparam logic [1:0] REG_SPACE = 2'd2;

  // Reset values of the length registers
  localparam logic [15:0] DIT_RESET   = 16'd1000;
  localparam logic [15:0] DAH_RESET   = 16'd3000;
  localparam logic [15:0] SPACE_RESET = 16'd3000;

  // Item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Character bounds
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_Z    = 8'h5A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Longest tone run of one character
  localparam int unsigned MAX_TONES = 5;

  typedef logic [MAX_TONES-1:0]         pat_t;
  typedef logic [$clog2(MAX_TONES+1)-1:0] len_t;

  // Input transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_t;

  // Result transaction
  typedef struct packed {
    elem_e       element;
    logic [15:0] duration;
    logic        last;
  } out_t;

  // Length registers as seen by the back end
  typedef struct packed {
    logic [15:0] dit_length;
    logic [15:0] dah_length;
    logic [15:0] space_length;
  } cfg_t;

  // Classified item: tone pattern, first element in the MSB, 1 = dah
  typedef struct packed {
    logic is_end;
    len_t len;
    pat_t pat;
  } desc_t;

  // Letter patterns A..Z, left aligned
  localparam pat_t LETTER_PAT [0:25] = '{
    5'b01000, 5'b10000, 5'b10100, 5'b10000, 5'b00000, 5'b00100, 5'b11000,
    5'b00000, 5'b00000, 5'b01110, 5'b10100, 5'b01000, 5'b11000, 5'b10000,
    5'b11100, 5'b01100, 5'b11010, 5'b01000, 5'b00000, 5'b10000, 5'b00100,
    5'b00010, 5'b01100, 5'b10010, 5'b10110, 5'b11000
  };

  localparam len_t LETTER_LEN [0:25] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3,
    3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2,
    3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3,
    3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // Digit patterns 0..9, all five elements long
  localparam pat_t DIGIT_PAT [0:9] = '{
    5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
    5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
  };

endpackage

// File: hdl/mces_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element sequencer front end
// Accepts input transactions, looks up the Morse pattern and pushes a
// descriptor into the queue. Unknown characters are dropped here.
// ----------------------------------------------------------------------------
module mces_front (
  input  mces_pkg::in_t   in_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            q_full_i,
  output logic            q_push_o,
  output mces_pkg::desc_t q_data_o
);

  logic       known;
  logic [7:0] letter_off;
  logic [7:0] digit_off;

  // Hold the input while the queue has no room
  assign in_stall_o = q_full_i;

  assign letter_off = in_data_i.char_code - mces_pkg::CHAR_A;
  assign digit_off  = in_data_i.char_code - mces_pkg::CHAR_ZERO;

  // Classify the character
  always_comb begin
    known           = 1'b1;
    q_data_o.is_end = 1'b0;
    q_data_o.len    = '0;
    q_data_o.pat    = '0;
    if (in_data_i.kind == mces_pkg::KIND_END) begin
      q_data_o.is_end = 1'b1;
    end else if (in_data_i.char_code inside {[mces_pkg::CHAR_A:mces_pkg::CHAR_Z]}) begin
      q_data_o.len = mces_pkg::LETTER_LEN[letter_off[4:0]];
      q_data_o.pat = mces_pkg::LETTER_PAT[letter_off[4:0]];
    end else if (in_data_i.char_code inside
                 {[mces_pkg::CHAR_ZERO:mces_pkg::CHAR_NINE]}) begin
      q_data_o.len = mces_pkg::len_t'(mces_pkg::MAX_TONES);
      q_data_o.pat = mces_pkg::DIGIT_PAT[digit_off[3:0]];
    end else begin
      known = 1'b0;
    end
  end

  // Push only items that produce elements
  assign q_push_o = in_valid_i && !q_full_i && known;

endmodule

// File: hdl/mces_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element sequencer descriptor queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mces_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mces_pkg::desc_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mces_pkg::desc_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  mces_pkg::desc_t  slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the slot
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/mces_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element sequencer back end
// Walks a descriptor to the output register, one element per unstalled cycle.
// ----------------------------------------------------------------------------
module mces_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mces_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  mces_pkg::desc_t q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mces_pkg::out_t  out_data_o
);

  logic            act_q;
  logic            end_half_q;
  mces_pkg::desc_t desc_q;
  logic            out_valid_q;
  mces_pkg::out_t  out_data_q;
  mces_pkg::out_t  elem;

  logic out_ready;
  logic fire;
  logic tone;
  logic done;
  logic load;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign fire      = act_q && out_ready;
  assign tone      = (desc_q.len != '0);
  assign done      = fire && elem.last;
  assign load      = (!act_q || done) && q_valid_i;
  assign q_pop_o   = load;

  // Build the current element
  always_comb begin
    if (tone) begin
      elem.element  = desc_q.pat[mces_pkg::MAX_TONES-1] ? mces_pkg::ELEM_DAH
                                                         : mces_pkg::ELEM_DIT;
      elem.duration = desc_q.pat[mces_pkg::MAX_TONES-1] ? cfg_i.dah_length
                                                         : cfg_i.dit_length;
      elem.last     = 1'b0;
    end else begin
      elem.element  = mces_pkg::ELEM_SPACE;
      elem.duration = cfg_i.space_length;
      elem.last     = !desc_q.is_end || end_half_q;
    end
  end

  // Load the next descriptor or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= 1'b0;
      end_half_q <= 1'b0;
    end else if (load) begin
      act_q      <= 1'b1;
      end_half_q <= 1'b0;
    end else if (done) begin
      act_q      <= 1'b0;
    end else if (fire && !tone) begin
      end_half_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= q_data_i;
    end else if (fire && tone) begin
      desc_q.len <= desc_q.len - 1'b1;
      desc_q.pat <= {desc_q.pat[mces_pkg::MAX_TONES-2:0], 1'b0};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= elem;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/morse_code_element_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse code element sequencer
// Turns characters and end-of-message markers into timed dit, dah and
// space elements.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------
//   input    | in        | in_valid_i / in_stall_o | in_data_i  (kind, char)
//   result   | out       | out_valid_o/out_stall_i | out_data_o (elem, dur, last)
//   config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A known character gives one element per tone and a closing space, two to
// six in all; an end marker gives two spaces and an unknown character none.
// The back end emits one element a cycle while the result is not stalled.
// Results pass through the queue, the descriptor and the output register.
// Reset clears the queue and all handshake state; lengths return to defaults.
// A stalled result holds the back end; the queue then fills and stalls input.
// ----------------------------------------------------------------------------
module morse_code_element_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mces_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mces_pkg::out_t      out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  mces_pkg::cfg_t  cfg_q;
  logic            push;
  logic            full;
  logic            pop;
  logic            q_valid;
  mces_pkg::desc_t front_desc;
  mces_pkg::desc_t back_desc;

  assign cfg_ready_o = 1'b1;

  // Length registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dit_length   <= mces_pkg::DIT_RESET;
      cfg_q.dah_length   <= mces_pkg::DAH_RESET;
      cfg_q.space_length <= mces_pkg::SPACE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mces_pkg::REG_DIT:   cfg_q.dit_length   <= cfg_data_i;
        mces_pkg::REG_DAH:   cfg_q.dah_length   <= cfg_data_i;
        mces_pkg::REG_SPACE: cfg_q.space_length <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mces_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (front_desc)
  );

  mces_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (back_desc)
  );

  mces_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (back_desc),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hdl/mces_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element sequencer port checker
// Watches the top-level ports for handshake and element-sequence slips.
// ----------------------------------------------------------------------------
module mces_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mces_pkg::out_t out_data_o,
  input logic           cfg_ready_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Tone elements never close a run
  a_tone_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.element == mces_pkg::ELEM_DIT ||
                    out_data_o.element == mces_pkg::ELEM_DAH)
    |-> !out_data_o.last)
    else $error("tone element flagged last");

  // A run always closes on a space
  a_last_is_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.element == mces_pkg::ELEM_SPACE)
    else $error("last element is not a space");

  // A tone is followed by more output of the same run
  a_tone_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.element != mces_pkg::ELEM_SPACE
    |=> out_valid_o)
    else $error("run broke off after a tone");

  // Configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind morse_code_element_sequencer_core mces_checker u_mces_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

// File: verif/mces_element_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element checker
// Watches the config, input and result channels of the element sequencer.
// Every accepted input item is expanded into the dit, dah and space elements
// it must produce, using the length registers as last written. Every accepted
// result is then compared field by field against the oldest of those.
// ----------------------------------------------------------------------------
module mces_element_checker
  import mces_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned elements_due_o,
  output int unsigned mismatches_o
);

  localparam byte DASH = "-";

  // International code, '.' for a dit and '-' for a dah
  string alpha_marks [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_marks [10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  logic [15:0] dit_len;
  logic [15:0] dah_len;
  logic [15:0] space_len;
  out_t        elements_due [$];
  int unsigned due_total      = 0;
  int unsigned mismatch_total = 0;

  assign elements_due_o = due_total;
  assign mismatches_o   = mismatch_total;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    mismatch_total++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic queue_element(input elem_e kind, input logic [15:0] dur, input logic last);
    out_t elem;
    elem.element  = kind;
    elem.duration = dur;
    elem.last     = last;
    elements_due.push_back(elem);
  endtask

  // Expand one input transaction into the elements it must produce
  task automatic encode_item(input in_t item);
    string marks;
    if (item.kind == KIND_END) begin
      queue_element(ELEM_SPACE, space_len, 1'b0);
      queue_element(ELEM_SPACE, space_len, 1'b1);
      return;
    end
    if (item.char_code >= CHAR_A && item.char_code <= CHAR_Z) begin
      marks = alpha_marks[item.char_code - CHAR_A];
    end else if (item.char_code >= CHAR_ZERO && item.char_code <= CHAR_NINE) begin
      marks = digit_marks[item.char_code - CHAR_ZERO];
    end else begin
      // Anything else, lower case included, is dropped silently
      return;
    end
    for (int i = 0; i < marks.len(); i++) begin
      if (marks[i] == DASH) begin
        queue_element(ELEM_DAH, dah_len, 1'b0);
      end else begin
        queue_element(ELEM_DIT, dit_len, 1'b0);
      end
    end
    queue_element(ELEM_SPACE, space_len, 1'b1);
  endtask

  // Compare one result transaction with the oldest expected element
  task automatic check_element(input out_t got);
    out_t want;
    if (elements_due.size() == 0) begin
      report_mismatch($sformatf("unexpected element %0d duration %0d last %0b",
                                got.element, got.duration, got.last));
      return;
    end
    want = elements_due.pop_front();
    if (got.element !== want.element) begin
      report_mismatch($sformatf("element %0d, want %0d", got.element, want.element));
    end
    if (got.duration !== want.duration) begin
      report_mismatch($sformatf("duration %0d, want %0d", got.duration, want.duration));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    end
  endtask

  // Track register writes, predict on input, check on output
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_len   = DIT_RESET;
      dah_len   = DAH_RESET;
      space_len = SPACE_RESET;
      elements_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DIT: begin
            dit_len = cfg_data_i;
          end
          REG_DAH: begin
            dah_len = cfg_data_i;
          end
          REG_SPACE: begin
            space_len = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        encode_item(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_element(out_data_i);
      end
    end
    due_total = elements_due.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element sequencer testbench
// Drives directed and random characters and end markers through the
// sequencer under several length settings, with random gaps on the input,
// random stalls on the result side, a long result hold-off and drain pauses.
// Checking is done by the element checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import mces_pkg::*;

  localparam logic [1:0] REG_NONE      = 2'd3;
  localparam int         SETTLE_CYCLES = 10;
  localparam int         DRAIN_LIMIT   = 5000;
  localparam int         LONG_HOLD     = 120;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int unsigned elements_due;
  int unsigned mismatches;

  // Pacing controls for the sender and the result sink
  bit tx_burst  = 1'b0;
  bit rx_eager  = 1'b0;
  int long_hold = 0;

  morse_code_element_sequencer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mces_element_checker u_monitor (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .elements_due_o (elements_due),
    .mismatches_o   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if the handshakes never complete
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_t make_item(input logic kind, input logic [7:0] code);
    in_t item;
    item.kind      = kind;
    item.char_code = code;
    return item;
  endfunction

  // Mostly encodable characters and end markers, some noise
  function automatic in_t random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return make_item(KIND_CHAR, CHAR_A + 8'($urandom_range(0, 25)));
    end
    if (pick < 65) begin
      return make_item(KIND_CHAR, CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
    if (pick < 77) begin
      return make_item(KIND_END, 8'($urandom));
    end
    return make_item(KIND_CHAR, 8'($urandom));
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 5))
      0: begin
        return 16'd0;
      end
      1: begin
        return 16'd1;
      end
      2: begin
        return 16'hFFFF;
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(input in_t item);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  // Stop offering and wait until every expected element has come out
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    // Let the monitor pick up the last accepted transaction first
    @(posedge clk);
    while (elements_due != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all length registers; the unused index comes first and must be ignored
  task automatic program_lengths(input logic [15:0] dit, input logic [15:0] dah,
                                 input logic [15:0] gap);
    write_reg(REG_NONE, 16'($urandom));
    write_reg(REG_DIT, dit);
    write_reg(REG_DAH, dah);
    write_reg(REG_SPACE, gap);
    cfg_valid <= 1'b0;
  endtask

  // Result sink: random stall per transaction, eager mode, long hold on request
  initial begin : result_sink
    int unsigned hold;
    forever begin
      if (long_hold != 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      hold = rx_eager ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && long_hold == 0);
    end
  end

  // Stimulus
  initial begin : stimulus
    string directed_text;
    directed_text = "AZ09ETQY5@[/:a";
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DIT;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table ends, single-element letters, bounds around the ranges
    for (int i = 0; i < directed_text.len(); i++) begin
      send_item(make_item(KIND_CHAR, directed_text[i]));
    end
    send_item(make_item(KIND_CHAR, 8'h00));
    send_item(make_item(KIND_CHAR, 8'hFF));
    send_item(make_item(KIND_CHAR, 8'h7F));
    send_item(make_item(KIND_END, CHAR_A));
    send_item(make_item(KIND_END, 8'hFF));
    drain();

    // Shortest dit, longest dah, zero-length space
    program_lengths(16'd1, 16'hFFFF, 16'd0);
    run_random(50);
    drain();

    // Back-to-back transactions with no result stalls
    program_lengths(16'hFFFF, 16'd0, 16'd1);
    tx_burst = 1'b1;
    rx_eager = 1'b1;
    run_random(35);
    tx_burst = 1'b0;
    rx_eager = 1'b0;
    drain();

    // Hold the result side long enough to back up the input
    program_lengths(pick_length(), pick_length(), pick_length());
    long_hold = LONG_HOLD;
    tx_burst  = 1'b1;
    run_random(25);
    tx_burst = 1'b0;
    drain();

    program_lengths(pick_length(), pick_length(), pick_length());
    run_random(50);
    drain();

    if (mismatches == 0 && elements_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: morse_code_element_sequencer_core.f
hdl/mces_pkg.sv
hdl/mces_front.sv
hdl/mces_queue.sv
hdl/mces_back.sv
hdl/morse_code_element_sequencer_core.sv
hdl/mces_checker.sv
verif/mces_element_checker.sv
verif/tb_top.sv
